// ===== sv/mnc_pkg.sv =====
// ----------------------------------------------------------------------------
// Multinomial coefficient package
// Shared widths, request/result structs, status codes and helpers.
// ----------------------------------------------------------------------------
package mnc_pkg;

  localparam int MAX_PARTS  = 8;
  localparam int MAX_TOTAL  = 20;
  localparam int VAL_W      = 5;
  localparam int CFG_W      = 4;
  localparam int CNT_W      = $clog2(MAX_PARTS + 1);
  localparam int IDX_W      = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int SUM_W      = VAL_W + CNT_W;
  localparam int COEFF_W    = 62;
  localparam int STAT_W     = 2;
  localparam int DIGIT_W    = 8;
  localparam int PROD_W     = 72;
  localparam int DIGITS     = PROD_W / DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(DIGITS);

  localparam logic [CFG_W-1:0]  CFG_RESET      = 4'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BIG_PART  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_SUM   = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] total;
    logic [VAL_W-1:0] part_0;
    logic [VAL_W-1:0] part_1;
    logic [VAL_W-1:0] part_2;
    logic [VAL_W-1:0] part_3;
    logic [VAL_W-1:0] part_4;
    logic [VAL_W-1:0] part_5;
    logic [VAL_W-1:0] part_6;
    logic [VAL_W-1:0] part_7;
  } in_req_t;

  typedef struct packed {
    logic [COEFF_W-1:0] coefficient;
    logic [STAT_W-1:0]  status;
  } out_rsp_t;

  typedef logic [MAX_PARTS-1:0][VAL_W-1:0] part_vec_t;

  // Request into the shared multiply / exact-divide unit
  typedef struct packed {
    logic               start;
    logic [COEFF_W-1:0] value;
    logic [VAL_W-1:0]   mult;
    logic [VAL_W-1:0]   divisor;
  } md_req_t;

  function automatic part_vec_t unpack_parts(input in_req_t req);
    part_vec_t pv;
    pv    = '0;
    pv[0] = req.part_0;
    pv[1] = req.part_1;
    pv[2] = req.part_2;
    pv[3] = req.part_3;
    pv[4] = req.part_4;
    pv[5] = req.part_5;
    pv[6] = req.part_6;
    pv[7] = req.part_7;
    return pv;
  endfunction

endpackage

// ===== sv/mnc_check.sv =====
// ----------------------------------------------------------------------------
// Multinomial coefficient request check
// Largest-part and sum checks over the parts in use, plus the total's range, giving the status code.
// ----------------------------------------------------------------------------
module mnc_check (
  input  mnc_pkg::in_req_t            req,
  input  logic [mnc_pkg::CNT_W-1:0]   parts,
  output logic [mnc_pkg::STAT_W-1:0]  status
);
  import mnc_pkg::*;

  part_vec_t        pv;
  logic [VAL_W-1:0] largest;
  logic [SUM_W-1:0] sum;

  always_comb begin
    pv      = unpack_parts(req);
    largest = '0;
    sum     = '0;
    for (int i = 0; i < MAX_PARTS; i++) begin
      if (i < int'(parts)) begin
        if (pv[i] > largest) begin
          largest = pv[i];
        end
        sum = sum + SUM_W'(pv[i]);
      end
    end
  end

  // Largest part first, then sum and range of the total
  always_comb begin
    if (largest > req.total) begin
      status = STAT_BIG_PART;
    end else if ((sum != SUM_W'(req.total)) || (req.total > VAL_W'(MAX_TOTAL))) begin
      status = STAT_BAD_SUM;
    end else begin
      status = STAT_OK;
    end
  end

endmodule

// ===== sv/mnc_muldiv.sv =====
// ----------------------------------------------------------------------------
// Multinomial coefficient multiply / exact-divide unit
// Registers value * mult on start, then long-divides by divisor one byte
// per cycle, most significant byte first.
// ----------------------------------------------------------------------------
module mnc_muldiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mnc_pkg::md_req_t            req,
  output logic                        done,
  output logic [mnc_pkg::COEFF_W-1:0] result
);
  import mnc_pkg::*;

  localparam int RAW_W = COEFF_W + VAL_W;

  logic                 busy_r;
  logic                 done_r;
  logic [DIG_CNT_W-1:0] cnt_r;
  logic [PROD_W-1:0]    prod_r;
  logic [PROD_W-1:0]    quo_r;
  logic [VAL_W-1:0]     rem_r;
  logic [VAL_W-1:0]     div_r;

  logic [RAW_W-1:0]         prod_raw;
  logic [VAL_W+DIGIT_W-1:0] step;

  // One radix-256 digit: restoring division of {rem, dig} by d
  function automatic logic [VAL_W+DIGIT_W-1:0] div_digit(
    input logic [VAL_W-1:0]   rem,
    input logic [DIGIT_W-1:0] dig,
    input logic [VAL_W-1:0]   d
  );
    logic [VAL_W:0]     r;
    logic [DIGIT_W-1:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int b = DIGIT_W - 1; b >= 0; b--) begin
      r = {r[VAL_W-1:0], dig[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return {r[VAL_W-1:0], q};
  endfunction

  assign prod_raw = RAW_W'(req.value) * RAW_W'(req.mult);
  assign step     = div_digit(rem_r, prod_r[PROD_W-1 -: DIGIT_W], div_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIG_CNT_W'(DIGITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod_r <= PROD_W'(prod_raw);
      rem_r  <= '0;
      div_r  <= req.divisor;
    end else if (busy_r) begin
      prod_r <= prod_r << DIGIT_W;
      quo_r  <= {quo_r[PROD_W-DIGIT_W-1:0], step[DIGIT_W-1:0]};
      rem_r  <= step[VAL_W+DIGIT_W-1:DIGIT_W];
    end
  end

  assign done   = done_r;
  assign result = quo_r[COEFF_W-1:0];

endmodule

// ===== sv/multinomial_coefficient_core.sv =====
// ----------------------------------------------------------------------------
// Multinomial coefficient core
// n! / (m1! ... mk!) over the first parts_in_use parts, built step by step.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid/in_ready, in_data) carry a total and eight parts.
//   One result per request leaves on out_valid/out_ready, out_data, holding
//   the coefficient and a status (ok, largest part too big, bad sum).
//   cfg_we/cfg_wdata write parts_in_use; write it only while the core is idle.
//   The core handles one request at a time: in_ready is high only in idle.
//   A request that fails a check goes from acceptance straight to the finish
//   state. A good one is built one factor per unit of the total: each factor
//   is a multiply and a byte-wide long divide in the shared multiply/divide
//   unit plus a sequencer step, and each part costs an extra sequencer step.
//   The next request is taken once the finish state has handed on its result.
//   A finished result sits in the output register; if the receiver stalls,
//   the next result waits in the sequencer until that register drains.
//   Synchronous reset clears the sequencer and the output valid, and sets
//   parts_in_use to 2.
// ----------------------------------------------------------------------------
module multinomial_coefficient_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mnc_pkg::in_req_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mnc_pkg::out_rsp_t         out_data,
  input  logic                      cfg_we,
  input  logic [mnc_pkg::CFG_W-1:0] cfg_wdata
);
  import mnc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_WAIT,
    ST_FINISH
  } state_t;

  state_t             state_r;
  logic [CFG_W-1:0]   parts_in_use_r;
  logic               out_valid_r;
  out_rsp_t           out_data_r;
  part_vec_t          parts_r;
  logic [CNT_W-1:0]   kcnt_r;
  logic [CNT_W-1:0]   idx_r;
  logic [VAL_W-1:0]   j_r;
  logic [VAL_W-1:0]   c_r;
  logic [COEFF_W-1:0] coeff_r;
  logic [STAT_W-1:0]  status_r;

  logic [CNT_W-1:0]   k_now;
  logic [STAT_W-1:0]  chk_status;
  logic [VAL_W-1:0]   part_cur;
  logic               idx_end;
  logic               part_end;
  md_req_t            md_req;
  logic               md_done;
  logic [COEFF_W-1:0] md_result;

  // Clamp the part count: zero counts as one, saturate at the field count
  always_comb begin
    if (parts_in_use_r == '0) begin
      k_now = CNT_W'(1);
    end else if (CNT_W'(parts_in_use_r) > CNT_W'(MAX_PARTS)) begin
      k_now = CNT_W'(MAX_PARTS);
    end else begin
      k_now = CNT_W'(parts_in_use_r);
    end
  end

  mnc_check u_check (
    .req    (in_data),
    .parts  (k_now),
    .status (chk_status)
  );

  assign part_cur = parts_r[idx_r[IDX_W-1:0]];
  assign idx_end  = (idx_r == kcnt_r);
  assign part_end = (j_r > part_cur);

  // Launch one factor step: value * (c + 1) / j
  always_comb begin
    md_req.start   = (state_r == ST_SEL) && !idx_end && !part_end;
    md_req.value   = coeff_r;
    md_req.mult    = c_r + 1'b1;
    md_req.divisor = j_r;
  end

  mnc_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .done   (md_done),
    .result (md_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parts_in_use_r <= CFG_RESET;
    end else if (cfg_we) begin
      parts_in_use_r <= cfg_wdata;
    end
  end

  // Sequencer: state, output register and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once the receiver takes it, unless a new one follows
      if (out_valid_r && out_ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            parts_r  <= unpack_parts(in_data);
            kcnt_r   <= k_now;
            idx_r    <= '0;
            j_r      <= VAL_W'(1);
            c_r      <= '0;
            coeff_r  <= COEFF_W'(1);
            status_r <= chk_status;
            state_r  <= (chk_status == STAT_OK) ? ST_SEL : ST_FINISH;
          end
        end
        ST_SEL: begin
          if (idx_end) begin
            state_r <= ST_FINISH;
          end else if (part_end) begin
            // advance to the next part, restart its divisor count
            idx_r <= idx_r + 1'b1;
            j_r   <= VAL_W'(1);
          end else begin
            c_r     <= c_r + 1'b1;
            j_r     <= j_r + 1'b1;
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (md_done) begin
            coeff_r <= md_result;
            state_r <= ST_SEL;
          end
        end
        ST_FINISH: begin
          // hold the result until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r            <= 1'b1;
            out_data_r.coefficient <= (status_r == STAT_OK) ? coeff_r : '0;
            out_data_r.status      <= status_r;
            state_r                <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != STAT_OK)) |-> (out_data.coefficient == '0))
    else $error("error result carries a non-zero coefficient");

  a_done_in_wait : assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> (state_r == ST_WAIT))
    else $error("divide unit finished while the sequencer was not waiting");

  a_err_skip : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (chk_status != STAT_OK)) |=> (state_r == ST_FINISH))
    else $error("failed request did not go straight to finish");

endmodule

// ===== verif/mnc_result_checker.sv =====
// ----------------------------------------------------------------------------
// Multinomial coefficient result checker
// Watches both channels and the parts_in_use write port, predicts each result
// and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module mnc_result_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  mnc_pkg::in_req_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  mnc_pkg::out_rsp_t         out_data,
  input  logic                      cfg_we,
  input  logic [mnc_pkg::CFG_W-1:0] cfg_wdata,
  output int                        mismatches,
  output int                        results_due
);
  import mnc_pkg::*;

  logic [CFG_W-1:0] parts_setting;
  out_rsp_t         coefficients_owed[$];
  out_rsp_t         owed;

  // n! / (m1! ... mk!) built as value * c / j, held exactly in PROD_W bits
  function automatic out_rsp_t predict_multinomial(input in_req_t req,
                                                   input logic [CFG_W-1:0] setting);
    logic [VAL_W-1:0]  part [MAX_PARTS];
    int unsigned       counted;
    int unsigned       largest;
    int unsigned       sum_in_use;
    int unsigned       factor;
    int unsigned       j;
    logic [PROD_W-1:0] product;
    out_rsp_t          rsp;
    part[0] = req.part_0;
    part[1] = req.part_1;
    part[2] = req.part_2;
    part[3] = req.part_3;
    part[4] = req.part_4;
    part[5] = req.part_5;
    part[6] = req.part_6;
    part[7] = req.part_7;
    counted = setting;
    if (counted < 1) counted = 1;
    if (counted > MAX_PARTS) counted = MAX_PARTS;
    largest    = 0;
    sum_in_use = 0;
    for (int i = 0; i < counted; i++) begin
      if (part[i] > largest) largest = part[i];
      sum_in_use += part[i];
    end
    rsp.coefficient = '0;
    rsp.status      = STAT_OK;
    if (largest > req.total) begin
      rsp.status = STAT_BIG_PART;
    end else if (sum_in_use != req.total || req.total > MAX_TOTAL) begin
      rsp.status = STAT_BAD_SUM;
    end else begin
      product = PROD_W'(1);
      factor  = 0;
      for (int i = 0; i < counted; i++) begin
        for (j = 1; j <= part[i]; j++) begin
          factor++;
          product = product * factor;
          product = product / j;
        end
      end
      rsp.coefficient = product[COEFF_W-1:0];
    end
    return rsp;
  endfunction

  always @(posedge clk) begin : track
    if (!rst_n) begin
      parts_setting = CFG_RESET;
      mismatches    = 0;
      coefficients_owed.delete();
    end else begin
      if (cfg_we) parts_setting = cfg_wdata;
      // retire the oldest prediction before taking a new request
      if (out_valid && out_ready) begin
        if (coefficients_owed.size() == 0) begin
          $error("result with nothing owed: coefficient %0d status %0d",
                 out_data.coefficient, out_data.status);
          mismatches++;
        end else begin
          owed = coefficients_owed.pop_front();
          if (out_data.coefficient !== owed.coefficient) begin
            $error("coefficient: expected %0d, actual %0d",
                   owed.coefficient, out_data.coefficient);
            mismatches++;
          end
          if (out_data.status !== owed.status) begin
            $error("status: expected %0d, actual %0d", owed.status, out_data.status);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        coefficients_owed.push_back(predict_multinomial(in_data, parts_setting));
    end
    results_due = coefficients_owed.size();
  end

endmodule

// ===== verif/multinomial_coefficient_core_tb.sv =====
// ----------------------------------------------------------------------------
// Multinomial coefficient core testbench
// Drives directed and random requests through several parts_in_use settings,
// with random gaps on the request side and random stalls on the result side.
// A checker beside the core predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module multinomial_coefficient_core_tb;
  import mnc_pkg::*;

  // allow for the slowest request; add the longest gap and
  // the longest stall, then allow a wide margin
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int REQS_PER_PHASE  = 60;
  localparam int PHASES          = 10;
  localparam int DRAIN_CYCLES    = 20;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_req_t          in_data;
  logic             out_valid;
  logic             out_ready;
  out_rsp_t         out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               mismatches;
  int               results_due;

  // parts_in_use as last written, used only to shape the stimulus
  logic [CFG_W-1:0] parts_active;
  // high for phases that run without gaps or stalls
  bit               steady;

  multinomial_coefficient_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mnc_result_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap length in cycles: mostly none, sometimes short, rarely long.
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Parts the core will count under the current setting (zero reads as one,
  // anything above eight reads as eight).
  function automatic int parts_counted();
    if (parts_active == 0) return 1;
    if (parts_active > MAX_PARTS) return MAX_PARTS;
    return parts_active;
  endfunction

  function automatic in_req_t make_req(input int t, p0, p1, p2, p3, p4, p5, p6, p7);
    in_req_t req;
    req.total  = VAL_W'(t);
    req.part_0 = VAL_W'(p0);
    req.part_1 = VAL_W'(p1);
    req.part_2 = VAL_W'(p2);
    req.part_3 = VAL_W'(p3);
    req.part_4 = VAL_W'(p4);
    req.part_5 = VAL_W'(p5);
    req.part_6 = VAL_W'(p6);
    req.part_7 = VAL_W'(p7);
    return req;
  endfunction

  // Mostly well-formed requests (parts in use sum to the total), the rest
  // broken: total beyond MAX_TOTAL, an oversize part, or a sum that misses.
  // Parts beyond the count carry noise and must be ignored by the core.
  function automatic in_req_t random_request();
    logic [VAL_W-1:0] part [MAX_PARTS];
    int               k;
    int               t;
    int               kind;
    int               pick;
    k    = parts_counted();
    kind = $urandom_range(0, 99);
    for (int i = 0; i < MAX_PARTS; i++) part[i] = VAL_W'($urandom_range(0, 31));
    t = (kind >= 75 && kind < 85) ? $urandom_range(21, 31) : $urandom_range(0, 20);
    for (int i = 0; i < k; i++) part[i] = '0;
    if ($urandom_range(0, 3) == 0) begin
      part[$urandom_range(0, k - 1)] = VAL_W'(t);
    end else begin
      repeat (t) begin
        pick = $urandom_range(0, k - 1);
        part[pick] = part[pick] + 1'b1;
      end
    end
    if (kind >= 85 && kind < 93) begin
      // push one part in use past the total
      t = $urandom_range(0, 30);
      for (int i = 0; i < k; i++) part[i] = VAL_W'($urandom_range(0, t));
      part[$urandom_range(0, k - 1)] = VAL_W'($urandom_range(t + 1, 31));
    end else if (kind >= 93) begin
      // raise the total so the parts fall short of it
      t = t + $urandom_range(1, 31 - t);
    end
    return make_req(t, part[0], part[1], part[2], part[3],
                    part[4], part[5], part[6], part[7]);
  endfunction

  // Present one request and hold it until the core takes it. Drop valid only
  // when a gap comes first; back-to-back requests keep valid high.
  task automatic push_request(input in_req_t req);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Write parts_in_use once the core has drained every outstanding request.
  task automatic write_parts(input logic [CFG_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= value;
    parts_active  = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: hold ready low for random stretches, except in steady phases.
  initial begin : result_stall
    int hold;
    out_ready = 1'b0;
    hold      = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = idle_gap();
      end
    end
  end

  // Give up after a long run of cycles in which nothing is accepted.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("multinomial_coefficient_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] phase_setting [PHASES];
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    steady       = 1'b0;
    parts_active = CFG_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting, two parts counted; noise in the ignored parts.
    push_request(make_req( 0,  0,  0, 31, 31, 31, 31, 31, 31)); // empty product is one
    push_request(make_req(20, 20,  0,  0,  0,  0,  0,  0,  0));
    push_request(make_req(20, 10, 10, 31, 31, 31, 31, 31, 31)); // widest binomial
    push_request(make_req(20,  0, 20, 17,  5,  9,  2, 30,  1));
    push_request(make_req(31, 31,  0,  0,  0,  0,  0,  0,  0)); // total beyond MAX_TOTAL
    push_request(make_req(21, 11, 10,  0,  0,  0,  0,  0,  0)); // total beyond MAX_TOTAL
    push_request(make_req( 3,  5,  0,  0,  0,  0,  0,  0,  0)); // oversize part
    push_request(make_req( 5,  6,  9,  0,  0,  0,  0,  0,  0)); // both fail: size wins
    push_request(make_req( 5,  2,  2, 31, 31, 31, 31, 31, 31)); // sum short
    push_request(make_req( 0,  0,  1,  0,  0,  0,  0,  0,  0)); // oversize against zero
    push_request(make_req(31, 31, 31, 31, 31, 31, 31, 31, 31)); // sum too large

    // All eight parts counted.
    write_parts(4'd8);
    push_request(make_req(20,  3,  3,  3,  3,  2,  2,  2,  2));
    push_request(make_req(20,  0,  0,  0,  0,  0,  0,  0, 20));
    push_request(make_req( 8,  1,  1,  1,  1,  1,  1,  1,  1));
    push_request(make_req(31,  4,  4,  4,  4,  4,  4,  4,  3)); // total beyond MAX_TOTAL
    push_request(make_req(20,  0,  0,  0,  0,  0,  0,  0, 21)); // last part oversize

    // A count of zero must behave as one.
    write_parts(4'd0);
    push_request(make_req( 7,  7,  5, 31, 31, 31, 31, 31, 31));
    push_request(make_req( 0,  0, 31, 31, 31, 31, 31, 31, 31));

    // Counts above eight saturate.
    write_parts(4'd15);
    push_request(make_req(16,  2,  2,  2,  2,  2,  2,  2,  2));
    push_request(make_req(20, 20,  0,  0,  0,  0,  0,  0,  0));

    // Random phases across settings, extremes included; every fourth phase
    // runs without gaps or stalls.
    phase_setting = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd3, 4'd2, 4'd9, 4'd5, 4'd4, 4'd7};
    phase_setting[PHASES-1] = CFG_W'($urandom_range(0, 15));
    for (int phase = 0; phase < PHASES; phase++) begin
      write_parts(phase_setting[phase]);
      steady = (phase % 4 == 3);
      repeat (REQS_PER_PHASE) push_request(random_request());
      steady = 1'b0;
    end

    // Drain: lower valid, wait for every owed result, then a short tail.
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && results_due == 0) begin
      $display("multinomial_coefficient_core regression: pass");
    end else begin
      $display("multinomial_coefficient_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mnc_pkg.sv
sv/mnc_check.sv
sv/mnc_muldiv.sv
sv/multinomial_coefficient_core.sv
verif/mnc_result_checker.sv
verif/multinomial_coefficient_core_tb.sv
